// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== design/gqm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package gqm_pkg;

  localparam int unsigned DEF_MAX_FEATURES = 4096;
  localparam int unsigned FEAT_CAP         = 4096;

  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CNT_W     = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRP_COLS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_ENABLE = 2'd3;

  localparam logic [CFG_W-1:0] RST_NUM_COLS = 13'd64;
  localparam logic [CFG_W-1:0] RST_GRP_COLS = 13'd32;
  localparam logic [CFG_W-1:0] RST_NUM_ROWS = 13'd64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PART,
    ST_SCALE,
    ST_ROUND,
    ST_ACC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic part;
    logic scale;
    logic round;
    logic acc;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic group_end;
    logic row_end;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [CFG_W-1:0] num_cols;
    logic [CFG_W-1:0] grp_cols;
    logic [CFG_W-1:0] num_rows;
    logic             bias_enable;
  } cfg_t;

  function automatic logic [CFG_W-1:0] eff_count(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] lim);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = {{(CFG_W-1){1'b0}}, 1'b1};
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/gqm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gqm_ctrl import gqm_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_MUL;
      end
      ST_MUL:   state_nxt = ST_PART;
      ST_PART:  state_nxt = sts.group_end ? ST_SCALE : ST_IDLE;
      ST_SCALE: state_nxt = ST_ROUND;
      ST_ROUND: state_nxt = ST_ACC;
      ST_ACC:   state_nxt = sts.row_end ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_MUL:   cmd.mul   = 1'b1;
      ST_PART:  cmd.part  = 1'b1;
      ST_SCALE: cmd.scale = 1'b1;
      ST_ROUND: cmd.round = 1'b1;
      ST_ACC:   cmd.acc   = 1'b1;
      ST_EMIT:  cmd.emit  = sts.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== design/gqm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gqm_datapath import gqm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  input  cfg_t               cfg,
  input  logic signed [7:0]  in_weight_value,
  input  logic signed [15:0] in_activation,
  input  logic signed [15:0] in_group_scale,
  input  logic signed [31:0] in_row_bias,
  output sts_t               sts,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_row_value,
  output logic [11:0]        out_row_index,
  output logic               out_last_row
);

  logic signed [7:0]  w_r;
  logic signed [15:0] a_r;
  logic signed [15:0] s_r;
  logic signed [31:0] b_r;

  logic signed [23:0] prod_r;
  logic signed [35:0] gp_r;
  logic signed [51:0] sprod_r;
  logic signed [39:0] scaled_r;
  logic signed [47:0] acc_r;

  logic [CNT_W-1:0] cc_r;
  logic [CNT_W-1:0] gcc_r;
  logic [CNT_W-1:0] rc_r;
  logic             grp_end_r;
  logic             row_end_r;
  logic             out_valid_r;

  logic [CNT_W-1:0] cc_inc;
  logic [CNT_W-1:0] gcc_inc;
  logic             row_end_nxt;
  logic             grp_end_nxt;
  logic [CFG_W-1:0] rc_inc;
  logic             last_nxt;
  logic [51:0]      rnd_sum;
  logic [48:0]      acc_sum;
  logic [47:0]      acc_nxt;
  logic [31:0]      out_sat;

  assign cc_inc      = cc_r + 12'd1;
  assign gcc_inc     = gcc_r + 12'd1;
  assign row_end_nxt = (cc_inc == '0) || ({1'b0, cc_inc} >= cfg.num_cols);
  assign grp_end_nxt = row_end_nxt || (gcc_inc == '0) ||
                       ({1'b0, gcc_inc} >= cfg.grp_cols);
  assign rc_inc      = {1'b0, rc_r} + 13'd1;
  assign last_nxt    = (rc_inc >= cfg.num_rows);

  assign rnd_sum = sprod_r + 52'sd2048;
  assign acc_sum = {acc_r[47], acc_r} + {{9{scaled_r[39]}}, scaled_r};

  always_comb begin
    if (acc_sum[48] != acc_sum[47]) begin
      acc_nxt = acc_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      acc_nxt = acc_sum[47:0];
    end
  end

  always_comb begin
    if ((&acc_r[47:31]) || !(|acc_r[47:31])) begin
      out_sat = acc_r[31:0];
    end else begin
      out_sat = acc_r[47] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_r <= in_weight_value;
      a_r <= in_activation;
      s_r <= in_group_scale;
      b_r <= in_row_bias;
    end
    if (cmd.mul) begin
      prod_r <= w_r * a_r;
    end
    if (cmd.scale) begin
      sprod_r <= gp_r * s_r;
    end
    if (cmd.round) begin
      scaled_r <= rnd_sum[51:12];
    end
    if (cmd.emit) begin
      out_row_value <= out_sat;
      out_row_index <= rc_r;
      out_last_row  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r        <= '0;
      gcc_r       <= '0;
      rc_r        <= '0;
      gp_r        <= '0;
      acc_r       <= '0;
      grp_end_r   <= 1'b0;
      row_end_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.mul) begin
        cc_r      <= row_end_nxt ? '0 : cc_inc;
        gcc_r     <= grp_end_nxt ? '0 : gcc_inc;
        grp_end_r <= grp_end_nxt;
        row_end_r <= row_end_nxt;
        if (cc_r == '0) begin
          acc_r <= cfg.bias_enable ? {{16{b_r[31]}}, b_r} : '0;
        end
      end
      if (cmd.part) begin
        gp_r <= gp_r + {{12{prod_r[23]}}, prod_r};
      end
      if (cmd.scale) begin
        gp_r <= '0;
      end
      if (cmd.acc) begin
        acc_r <= acc_nxt;
      end
      if (cmd.emit) begin
        rc_r        <= last_nxt ? '0 : rc_inc[CNT_W-1:0];
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.group_end = grp_end_r;
  assign sts.row_end   = row_end_r;
  assign sts.out_free  = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;

endmodule
`default_nettype wire

// ===== design/group_quantized_int8_matvec_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel  direction  handshake            payload
// in_      input      in_valid/in_ready    weight_value, activation, group_scale, row_bias
// out_     output     out_valid/out_ready  row_value, row_index, last_row
// cfg_     input      cfg_wr_en            cfg_index, cfg_wdata
//
// Each item goes through multiply and add to group partial; one that closes a group
// goes on to scale multiply, round and row add, and one that closes a row to emit.
// The row end waits in its last step while the output register is still full.
// Reset is synchronous and clears counters, accumulators and the output valid.
// The input is not taken again until the current item has finished.
`include "assert_macros.svh"
module group_quantized_int8_matvec_core import gqm_pkg::*; #(
  parameter int unsigned MAX_FEATURES = DEF_MAX_FEATURES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [7:0]    in_weight_value,
  input  logic signed [15:0]   in_activation,
  input  logic signed [15:0]   in_group_scale,
  input  logic signed [31:0]   in_row_bias,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_row_value,
  output logic [11:0]          out_row_index,
  output logic                 out_last_row,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int unsigned LIMIT_INT = (MAX_FEATURES < FEAT_CAP) ? MAX_FEATURES : FEAT_CAP;
  localparam logic [CFG_W-1:0] LIMIT = CFG_W'(LIMIT_INT);

  logic [CFG_W-1:0] num_cols_r;
  logic [CFG_W-1:0] grp_cols_r;
  logic [CFG_W-1:0] num_rows_r;
  logic             bias_enable_r;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cols_r    <= RST_NUM_COLS;
      grp_cols_r    <= RST_GRP_COLS;
      num_rows_r    <= RST_NUM_ROWS;
      bias_enable_r <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_NUM_COLS:    num_cols_r    <= cfg_wdata;
        CFG_GRP_COLS:    grp_cols_r    <= cfg_wdata;
        CFG_NUM_ROWS:    num_rows_r    <= cfg_wdata;
        CFG_BIAS_ENABLE: bias_enable_r <= cfg_wdata[0];
        default: begin
          num_cols_r <= num_cols_r;
        end
      endcase
    end
  end

  assign cfg.num_cols    = eff_count(num_cols_r, LIMIT);
  assign cfg.grp_cols    = eff_count(grp_cols_r, LIMIT);
  assign cfg.num_rows    = eff_count(num_rows_r, LIMIT);
  assign cfg.bias_enable = bias_enable_r;

  gqm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gqm_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg             (cfg),
    .in_weight_value (in_weight_value),
    .in_activation   (in_activation),
    .in_group_scale  (in_group_scale),
    .in_row_bias     (in_row_bias),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_row_value   (out_row_value),
    .out_row_index   (out_row_index),
    .out_last_row    (out_last_row)
  );

  `ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)
  `ASSERT_IMP(a_cmd_onehot, clk, rst_n, 1'b1, $onehot0(cmd))
  `ASSERT_IMP(a_emit_free, clk, rst_n, cmd.emit, sts.out_free)
  `ASSERT_NEXT(a_emit_valid, clk, rst_n, cmd.emit, out_valid)

endmodule
`default_nettype wire

// ===== bench/gqm_row_checker.sv =====
`timescale 1ns / 1ps
module gqm_row_checker import gqm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic signed [7:0]    in_weight_value,
  input  logic signed [15:0]   in_activation,
  input  logic signed [15:0]   in_group_scale,
  input  logic signed [31:0]   in_row_bias,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic signed [31:0]   out_row_value,
  input  logic [11:0]          out_row_index,
  input  logic                 out_last_row,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   mismatches,
  output int                   rows_waiting,
  output int                   rows_checked
);

  localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam longint ROW_HI = 64'sd2147483647;
  localparam longint ROW_LO = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] value;
    logic [11:0]        index;
    logic               last;
  } row_result_t;

  row_result_t      expected_rows[$];
  logic [CFG_W-1:0] n_cols_reg;
  logic [CFG_W-1:0] n_group_reg;
  logic [CFG_W-1:0] n_rows_reg;
  logic             bias_on;
  logic [CNT_W-1:0] col_cnt;
  logic [CNT_W-1:0] grp_cnt;
  logic [CNT_W-1:0] row_cnt;
  longint           grp_sum;
  longint           row_sum;
  int               fails = 0;
  int               checked = 0;

  function automatic int clamp_count(input logic [CFG_W-1:0] v);
    int lim;
    lim = (FEAT_CAP < DEF_MAX_FEATURES) ? FEAT_CAP : DEF_MAX_FEATURES;
    if (v == '0) return 1;
    if (int'(v) > lim) return lim;
    return int'(v);
  endfunction

  task automatic fold_weight(input logic signed [7:0] w, input logic signed [15:0] a,
                             input logic signed [15:0] s, input logic signed [31:0] b);
    int          n_cols;
    int          n_group;
    int          n_rows;
    bit          row_done;
    bit          last;
    longint      scaled;
    longint      total;
    row_result_t r;
    n_cols  = clamp_count(n_cols_reg);
    n_group = clamp_count(n_group_reg);
    n_rows  = clamp_count(n_rows_reg);
    if (col_cnt == '0) row_sum = bias_on ? longint'(b) : 64'sd0;
    grp_sum = grp_sum + longint'(w) * longint'(a);
    col_cnt = col_cnt + 1'b1;
    grp_cnt = grp_cnt + 1'b1;
    row_done = (col_cnt == '0) || (int'(col_cnt) >= n_cols);
    if (row_done || grp_cnt == '0 || int'(grp_cnt) >= n_group) begin
      // round half up from Q.20 back to Q.8
      scaled = (grp_sum * longint'(s) + 64'sd2048) >>> 12;
      total  = row_sum + scaled;
      if (total > ACC_HI) total = ACC_HI;
      if (total < ACC_LO) total = ACC_LO;
      row_sum = total;
      grp_sum = 0;
      grp_cnt = '0;
    end
    if (row_done) begin
      last  = (int'(row_cnt) + 1 >= n_rows);
      total = row_sum;
      if (total > ROW_HI) total = ROW_HI;
      if (total < ROW_LO) total = ROW_LO;
      r.value = total[31:0];
      r.index = row_cnt;
      r.last  = last;
      expected_rows.push_back(r);
      col_cnt = '0;
      grp_cnt = '0;
      row_cnt = last ? '0 : row_cnt + 1'b1;
    end
  endtask

  always @(posedge clk) begin : watch
    row_result_t want;
    if (!rst_n) begin
      n_cols_reg  = RST_NUM_COLS;
      n_group_reg = RST_GRP_COLS;
      n_rows_reg  = RST_NUM_ROWS;
      bias_on     = 1'b0;
      col_cnt     = '0;
      grp_cnt     = '0;
      row_cnt     = '0;
      grp_sum     = 0;
      row_sum     = 0;
      expected_rows.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_rows.size() == 0) begin
          fails++;
          $display("%0t: unexpected row transfer: value %0d index %0d last %0b",
                   $time, out_row_value, out_row_index, out_last_row);
        end else begin
          want = expected_rows.pop_front();
          checked++;
          if (out_row_value !== want.value) begin
            fails++;
            $display("%0t: row_value expected %0d actual %0d",
                     $time, want.value, out_row_value);
          end
          if (out_row_index !== want.index) begin
            fails++;
            $display("%0t: row_index expected %0d actual %0d",
                     $time, want.index, out_row_index);
          end
          if (out_last_row !== want.last) begin
            fails++;
            $display("%0t: last_row expected %0b actual %0b",
                     $time, want.last, out_last_row);
          end
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_NUM_COLS:    n_cols_reg = cfg_wdata;
          CFG_GRP_COLS:    n_group_reg = cfg_wdata;
          CFG_NUM_ROWS:    n_rows_reg = cfg_wdata;
          CFG_BIAS_ENABLE: bias_on = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        fold_weight(in_weight_value, in_activation, in_group_scale, in_row_bias);
      end
    end
    mismatches   <= fails;
    rows_waiting <= expected_rows.size();
    rows_checked <= checked;
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import gqm_pkg::*;

  localparam int QUIET_CYCLES = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 1600;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [7:0]    in_weight_value = '0;
  logic signed [15:0]   in_activation = '0;
  logic signed [15:0]   in_group_scale = '0;
  logic signed [31:0]   in_row_bias = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [31:0]   out_row_value;
  logic [11:0]          out_row_index;
  logic                 out_last_row;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  int mismatches;
  int rows_waiting;
  int rows_checked;
  int sent = 0;
  int settings = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  group_quantized_int8_matvec_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_weight_value(in_weight_value),
    .in_activation  (in_activation),
    .in_group_scale (in_group_scale),
    .in_row_bias    (in_row_bias),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_row_value  (out_row_value),
    .out_row_index  (out_row_index),
    .out_last_row   (out_last_row),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  gqm_row_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_weight_value(in_weight_value),
    .in_activation  (in_activation),
    .in_group_scale (in_group_scale),
    .in_row_bias    (in_row_bias),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_row_value  (out_row_value),
    .out_row_index  (out_row_index),
    .out_last_row   (out_last_row),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatches     (mismatches),
    .rows_waiting   (rows_waiting),
    .rows_checked   (rows_checked)
  );

  function automatic logic [31:0] pick_field(input int bits);
    logic [31:0] hi;
    hi = 32'hffff_ffff >> (33 - bits);
    case ($urandom_range(9))
      0: return ~hi;
      1: return hi;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [CFG_W-1:0] n_cols, input logic [CFG_W-1:0] n_group,
                               input logic [CFG_W-1:0] n_rows, input logic [CFG_W-1:0] bias_word);
    write_reg(CFG_NUM_COLS, n_cols);
    write_reg(CFG_GRP_COLS, n_group);
    write_reg(CFG_NUM_ROWS, n_rows);
    write_reg(CFG_BIAS_ENABLE, bias_word);
    cfg_wr_en <= 1'b0;
    settings++;
  endtask

  task automatic send_weight(input logic [7:0] w, input logic [15:0] a,
                             input logic [15:0] s, input logic [31:0] b);
    if (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (!calm && $urandom_range(99) < 30) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_weight_value <= w;
    in_activation   <= a;
    in_group_scale  <= s;
    in_row_bias     <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_random(input bit hot, input bit neg);
    if (hot && $urandom_range(4) != 0) begin
      send_weight(8'h80, 16'h8000, neg ? 16'h8000 : 16'h7fff, pick_field(32));
    end else begin
      send_weight(8'(pick_field(8)), 16'(pick_field(16)), 16'(pick_field(16)),
                  pick_field(32));
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rows_waiting != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= calm || ($urandom_range(99) >= 30);
    end
  end

  initial begin
    #4_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    int kind;
    int n_cols;
    int n_group;
    int n_rows;
    int count;
    int rand_sent;
    bit hot;
    bit neg;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // two rows of five with a short final group and bias extremes
    load_settings(13'd5, 13'd2, 13'd2, 13'd1);
    send_weight(8'h80, 16'h8000, 16'h8000, 32'h7fff_ffff);
    send_weight(8'h7f, 16'h7fff, 16'h7fff, 32'h0000_0000);
    send_weight(8'h00, 16'h0100, 16'h1000, 32'hffff_ffff);
    send_weight(8'h01, 16'h0080, 16'h0800, 32'h0000_0000);
    send_weight(8'hff, 16'h0080, 16'h0800, 32'h0000_0000);
    send_weight(8'h7f, 16'h7fff, 16'h7fff, 32'h8000_0000);
    send_weight(8'h80, 16'h7fff, 16'h8000, 32'h0000_0000);
    send_weight(8'h7f, 16'h8000, 16'h8000, 32'h0000_0000);
    send_weight(8'hff, 16'hffff, 16'hffff, 32'h0000_0000);
    send_weight(8'h01, 16'h0001, 16'h0001, 32'h0000_0000);
    settle();

    // zero sizes act as one: every transfer closes a row; hold the output meanwhile
    load_settings(13'd0, 13'd0, 13'd0, 13'h1ffe);
    hold_req <= 1'b1;
    repeat (6) send_random(1'b0, 1'b0);
    settle();

    // group wider than the row
    load_settings(13'd3, 13'h1fff, 13'd3, 13'h0001);
    send_weight(8'h80, 16'h8000, 16'h7fff, 32'h8000_0000);
    send_weight(8'h80, 16'h8000, 16'h7fff, 32'h7fff_ffff);
    send_weight(8'h7f, 16'h7fff, 16'h8000, 32'h1234_5678);
    settle();

    rand_sent = 0;
    while (rand_sent < RANDOM_ITEMS) begin
      calm = (rand_sent >= 500 && rand_sent < 900);
      kind = $urandom_range(9);
      hot  = (kind == 0);
      neg  = 1'($urandom_range(1));
      case (kind)
        0: begin
          n_cols  = $urandom_range(64, 160);
          n_group = $urandom_range(1, n_cols);
          n_rows  = $urandom_range(1, 5);
          count   = $urandom_range(150, 300);
        end
        1: begin
          n_cols  = $urandom_range(2);
          n_group = $urandom_range(1) ? 8191 : 4096;
          n_rows  = $urandom_range(1) ? 4096 : $urandom_range(3);
          count   = $urandom_range(10, 40);
        end
        default: begin
          n_cols  = $urandom_range(1, 24);
          n_group = $urandom_range(0, n_cols + 2);
          n_rows  = ($urandom_range(9) == 0) ? 8191 : $urandom_range(6);
          count   = $urandom_range(10, 120);
        end
      endcase
      load_settings(CFG_W'(n_cols), CFG_W'(n_group), CFG_W'(n_rows),
                    CFG_W'($urandom_range(8191)));
      repeat (count) send_random(hot, neg);
      rand_sent += count;
      settle();
    end
    calm = 1'b0;

    $display("testbench: %0d weight transfers, %0d register settings, %0d rows compared",
             sent, settings, rows_checked);
    $display("testbench: short groups, zero and clamped sizes, %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== group_quantized_int8_matvec_core.f =====
+incdir+design
design/gqm_pkg.sv
design/gqm_ctrl.sv
design/gqm_datapath.sv
design/group_quantized_int8_matvec_core.sv
bench/gqm_row_checker.sv
bench/testbench.sv
